[rtl/ssit_pkg.sv]
// ssit_pkg: shared types and constants for the short string intern table.
// Holds FNV-1a constants, outcome codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package ssit_pkg;

	localparam int TABLE_SLOTS_DEF = 4096;
	localparam int MAX_BYTES_DEF   = 16;

	localparam int LEN_W    = 5;   // stored string length
	localparam int HANDLE_W = 12;  // handle field width
	localparam int HASH_W   = 32;
	localparam int INLEN_W  = 16;  // length field width
	localparam int OUT_W    = 3;

	localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
	localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

	typedef enum logic [OUT_W-1:0] {
		OUT_EMPTY     = 3'd0,
		OUT_SINGLE    = 3'd1,
		OUT_HIT       = 3'd2,
		OUT_INSERTED  = 3'd3,
		OUT_TOO_LONG  = 3'd4,
		OUT_COLLISION = 3'd5
	} outcome_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_HASH,
		ST_MOD,
		ST_READ,
		ST_FIN_SHORT,
		ST_FIN_TABLE
	} state_t;

	typedef struct packed {
		logic     clr_wr;     // clearing pass write
		logic     capture;    // latch input word
		logic     hash_init;  // load basis and byte shifter
		logic     hash_step;  // one FNV-1a round
		logic     mod_step;   // one slot remainder step
		logic     rd_en;      // table read
		logic     tbl_wr;     // fill slot
		logic     load_out;   // load output register
		outcome_t outcome;
	} ssit_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic len_zero;
		logic len_one;
		logic len_long;
		logic hash_last;
		logic mod_last;
		logic slot_used;
		logic slot_match;
	} ssit_sts_t;

endpackage

[rtl/short_string_intern_table_unit.sv]
// short_string_intern_table_unit: top level of the short string intern table.
// Instantiates ssit_ctrl (sequencer) and ssit_dp (hash, remainder, table).
// Depends on ssit_pkg.
//
//  channel | handshake          | word fields
//  --------+--------------------+--------------------------------------
//  in      | in_valid/in_stall  | bytes_low, bytes_high, length
//  out     | out_valid/out_stall| outcome, handle, hash_value
//
// Steps: length 0, 1 or above MAX_BYTES goes through accept, classify and
// finish. Lengths 2..MAX_BYTES go through accept, classify, one FNV-1a round
// per byte through a single 32-bit multiply, then one table read and a
// finish step with compare and fill. A TABLE_SLOTS that is not a power of
// two adds the slot remainder by reciprocal multiply before the table read.
// Reset: a clearing pass writes every slot unused, with in_stall held
// high. Stalls: one word is worked on at a time; a new word is taken
// while the previous result waits in the output register.
module short_string_intern_table_unit #(
	parameter int TABLE_SLOTS = ssit_pkg::TABLE_SLOTS_DEF,
	parameter int MAX_BYTES   = ssit_pkg::MAX_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [63:0]                     bytes_low,
	input  logic [63:0]                     bytes_high,
	input  logic [ssit_pkg::INLEN_W-1:0]    length,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ssit_pkg::OUT_W-1:0]      outcome,
	output logic [ssit_pkg::HANDLE_W-1:0]   handle,
	output logic [ssit_pkg::HASH_W-1:0]     hash_value
);
	import ssit_pkg::*;

	ssit_cmd_t cmd;
	ssit_sts_t sts;

	// sequencer: owns the handshakes, issues one command set per cycle
	ssit_ctrl #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: hash round, remainder, slot memory, result register
	ssit_dp #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.MAX_BYTES  (MAX_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes_low (bytes_low),
		.bytes_high(bytes_high),
		.length    (length),
		.cmd       (cmd),
		.sts       (sts),
		.outcome   (outcome),
		.handle    (handle),
		.hash_value(hash_value)
	);

endmodule

[rtl/ssit_ctrl.sv]
// ssit_ctrl: sequencing state machine for the intern table.
// Drives ssit_cmd_t to the datapath from ssit_sts_t; owns both handshakes.
// Depends on ssit_pkg.
module ssit_ctrl #(
	parameter int TABLE_SLOTS = ssit_pkg::TABLE_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  ssit_pkg::ssit_sts_t sts,
	output ssit_pkg::ssit_cmd_t cmd
);
	import ssit_pkg::*;

	localparam bit POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.len_zero || sts.len_one || sts.len_long) state_d = ST_FIN_SHORT;
				else state_d = ST_HASH;
			end
			ST_HASH: begin
				if (sts.hash_last) state_d = POW2 ? ST_READ : ST_MOD;
			end
			ST_MOD: begin
				if (sts.mod_last) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_FIN_TABLE;
			end
			ST_FIN_SHORT, ST_FIN_TABLE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		cmd.outcome = OUT_EMPTY;
		case (state_q)
			ST_CLEAR:  cmd.clr_wr = 1'b1;
			ST_IDLE:   cmd.capture = in_valid;
			ST_DECIDE: cmd.hash_init = 1'b1;
			ST_HASH:   cmd.hash_step = 1'b1;
			ST_MOD:    cmd.mod_step = 1'b1;
			ST_READ:   cmd.rd_en = 1'b1;
			ST_FIN_SHORT: begin
				cmd.load_out = out_free;
				if (sts.len_zero)     cmd.outcome = OUT_EMPTY;
				else if (sts.len_one) cmd.outcome = OUT_SINGLE;
				else                  cmd.outcome = OUT_TOO_LONG;
			end
			ST_FIN_TABLE: begin
				cmd.load_out = out_free;
				if (!sts.slot_used) begin
					cmd.outcome = OUT_INSERTED;
					cmd.tbl_wr  = out_free;
				end else if (sts.slot_match) begin
					cmd.outcome = OUT_HIT;
				end else begin
					cmd.outcome = OUT_COLLISION;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)     out_valid_q <= 1'b1;
			else if (!out_stall)  out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	// a slot is only ever filled when the read showed it unused
	a_wr_unused: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tbl_wr |-> (state_q == ST_FIN_TABLE) && !sts.slot_used)
		else $error("table write into a used slot");

	// output register never overwritten while a word is stalled
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result overwrote a stalled word");

	// every new result comes from a finish state
	a_rose_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.load_out))
		else $error("out_valid rose without a load");

	// an accepted word is classified on the next cycle
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_DECIDE))
		else $error("captured word not classified");
`endif

endmodule

[rtl/ssit_dp.sv]
// ssit_dp: datapath for the intern table: input capture, FNV-1a round,
// reciprocal slot remainder, slot memory and output register.
// Depends on ssit_pkg; controlled by ssit_ctrl.
module ssit_dp #(
	parameter int TABLE_SLOTS = ssit_pkg::TABLE_SLOTS_DEF,
	parameter int MAX_BYTES   = ssit_pkg::MAX_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [63:0]                     bytes_low,
	input  logic [63:0]                     bytes_high,
	input  logic [ssit_pkg::INLEN_W-1:0]    length,
	input  ssit_pkg::ssit_cmd_t             cmd,
	output ssit_pkg::ssit_sts_t             sts,
	output logic [ssit_pkg::OUT_W-1:0]      outcome,
	output logic [ssit_pkg::HANDLE_W-1:0]   handle,
	output logic [ssit_pkg::HASH_W-1:0]     hash_value
);
	import ssit_pkg::*;

	localparam int  SW   = $clog2(TABLE_SLOTS);
	localparam int  KW   = 8 * MAX_BYTES;
	localparam int  MW   = 1 + LEN_W + KW;
	localparam bit  POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
	// floor(2^32 / slots): quotient estimate is low by at most one
	localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / TABLE_SLOTS);

	logic [KW-1:0]      key_q, key_m, sh_q;
	logic [INLEN_W-1:0] len_q;
	logic [HASH_W-1:0]  h_q, h_round;
	logic [4:0]         cnt_q;
	logic [SW-1:0]      rem_q, rem_d, slot, clr_q;
	logic [2*HASH_W-1:0] q_prod;
	logic [HASH_W-1:0]  quo_q, rem_w, rem_w_q;
	logic [MW-1:0]      mem [TABLE_SLOTS];
	logic [MW-1:0]      rd_q;
	logic [MW-1:0]      wr_data;
	logic [SW-1:0]      wr_addr;
	logic               wr_en;
	logic [OUT_W-1:0]   outcome_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [HASH_W-1:0]  hash_q;

	// bytes at and above the length read as zero
	always_comb begin
		for (int i = 0; i < MAX_BYTES; i++) begin
			key_m[8*i +: 8] = (INLEN_W'(i) < len_q) ? key_q[8*i +: 8] : 8'd0;
		end
	end

	assign h_round = (h_q ^ {24'd0, sh_q[7:0]}) * FNV_PRIME;

	// remainder: quotient estimate, partial remainder, one correction
	assign q_prod  = 64'(h_q) * 64'(RECIP);
	assign rem_w   = h_q - quo_q * HASH_W'(TABLE_SLOTS);
	assign rem_d   = (rem_w_q >= HASH_W'(TABLE_SLOTS)) ?
	                 SW'(rem_w_q - HASH_W'(TABLE_SLOTS)) : SW'(rem_w_q);
	assign slot    = POW2 ? h_q[SW-1:0] : rem_q;

	assign sts.clr_last   = (clr_q == SW'(TABLE_SLOTS - 1));
	assign sts.len_zero   = (len_q == '0);
	assign sts.len_one    = (len_q == INLEN_W'(1));
	assign sts.len_long   = (len_q > INLEN_W'(MAX_BYTES));
	assign sts.hash_last  = (cnt_q == (5'(len_q) - 5'd1));
	assign sts.mod_last   = (cnt_q == 5'd2);
	assign sts.slot_used  = rd_q[MW-1];
	assign sts.slot_match = (rd_q[MW-2 -: LEN_W] == 5'(len_q)) && (rd_q[KW-1:0] == key_m);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q <= KW'({bytes_high, bytes_low});
			len_q <= length;
		end
		if (cmd.hash_init) begin
			h_q   <= FNV_BASIS;
			sh_q  <= key_q;
			cnt_q <= 5'd0;
			rem_q <= '0;
		end else if (cmd.hash_step) begin
			h_q   <= h_round;
			sh_q  <= sh_q >> 8;
			cnt_q <= sts.hash_last ? 5'd0 : cnt_q + 5'd1;
		end else if (cmd.mod_step) begin
			case (cnt_q)
				5'd0:    quo_q   <= q_prod[2*HASH_W-1:HASH_W];
				5'd1:    rem_w_q <= rem_w;
				default: rem_q   <= rem_d;
			endcase
			cnt_q <= cnt_q + 5'd1;
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + SW'(1);
		end
	end

	// slot memory: {used, length, bytes}
	assign wr_en   = cmd.clr_wr || cmd.tbl_wr;
	assign wr_addr = cmd.clr_wr ? clr_q : slot;
	assign wr_data = cmd.clr_wr ? '0 : {1'b1, 5'(len_q), key_m};

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd_en) rd_q <= mem[slot];
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			outcome_q <= cmd.outcome;
			case (cmd.outcome)
				OUT_SINGLE:               handle_q <= HANDLE_W'(key_q[7:0]);
				OUT_HIT, OUT_INSERTED:    handle_q <= HANDLE_W'(slot);
				default:                  handle_q <= '0;
			endcase
			case (cmd.outcome)
				OUT_HIT, OUT_INSERTED, OUT_COLLISION: hash_q <= h_q;
				default:                              hash_q <= '0;
			endcase
		end
	end

	assign outcome    = outcome_q;
	assign handle     = handle_q;
	assign hash_value = hash_q;

endmodule
